// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the receiver top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion on the block clock and reset.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif

`endif

// File: sv/wfr_pkg.sv
// ----------------------------------------------------------------------------
// Word frame receiver package
// Shared widths, codes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
package wfr_pkg;

  localparam int unsigned WORD_W        = 16;
  localparam int unsigned TYPE_W        = 8;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned WCOUNT_W      = 4;
  localparam int unsigned DIDX_W        = 3;
  localparam int unsigned MAX_WORDS_DEF = 8;
  localparam logic [WORD_W-1:0] SYNC_RESET = 16'hA55A;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC   = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BADC  = 2'd3;

  // Receiver phases.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_CSUM = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_HUNT_CHK,
    OP_HEAD_LOAD,
    OP_DATA_STORE,
    OP_CLR_IDX,
    OP_RD,
    OP_INC_IDX,
    OP_EMIT_DATA,
    OP_EMIT_BADH,
    OP_EMIT_BADC,
    OP_EMIT_EMPTY,
    OP_SET_HUNT
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_INPUT,
    C_DISABLED,
    C_REARM,
    C_PH_HUNT,
    C_PH_HEAD,
    C_PH_DATA,
    C_SUM_BAD,
    C_EXP_ZERO,
    C_MORE,
    C_EMIT_WAIT,
    C_BAD_HDR
  } cond_e;

  localparam int unsigned UPC_W = 5;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Datapath status seen by the sequencer's jump logic.
  typedef struct packed {
    logic no_input;
    logic disabled;
    logic rearm;
    logic ph_hunt;
    logic ph_head;
    logic ph_data;
    logic sum_bad;
    logic exp_zero;
    logic more;
    logic emit_wait;
    logic bad_hdr;
  } wfr_flags_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TYPE_W-1:0]   frame_type;
    logic [WCOUNT_W-1:0] word_count;
    logic [DIDX_W-1:0]   data_index;
    logic [WORD_W-1:0]   data_word;
    logic                last;
  } out_item_t;

  // Microcode step addresses.
  localparam logic [UPC_W-1:0] U_FETCH    = 5'd0;
  localparam logic [UPC_W-1:0] U_CHK_EN   = 5'd1;
  localparam logic [UPC_W-1:0] U_CHK_CMD  = 5'd2;
  localparam logic [UPC_W-1:0] U_DSP_HUNT = 5'd3;
  localparam logic [UPC_W-1:0] U_DSP_HEAD = 5'd4;
  localparam logic [UPC_W-1:0] U_DSP_DATA = 5'd5;
  localparam logic [UPC_W-1:0] U_CSUM     = 5'd6;
  localparam logic [UPC_W-1:0] U_CHK_ZERO = 5'd7;
  localparam logic [UPC_W-1:0] U_LOOP_RD  = 5'd8;
  localparam logic [UPC_W-1:0] U_LOOP_EM  = 5'd9;
  localparam logic [UPC_W-1:0] U_LOOP_NX  = 5'd10;
  localparam logic [UPC_W-1:0] U_LOOP_END = 5'd11;
  localparam logic [UPC_W-1:0] U_HUNT     = 5'd12;
  localparam logic [UPC_W-1:0] U_HEAD     = 5'd13;
  localparam logic [UPC_W-1:0] U_HEAD_LD  = 5'd14;
  localparam logic [UPC_W-1:0] U_BADH     = 5'd15;
  localparam logic [UPC_W-1:0] U_SETHUNT  = 5'd16;
  localparam logic [UPC_W-1:0] U_DATA     = 5'd17;
  localparam logic [UPC_W-1:0] U_BADC     = 5'd18;
  localparam logic [UPC_W-1:0] U_BADC_END = 5'd19;
  localparam logic [UPC_W-1:0] U_EMPTY    = 5'd20;
  localparam logic [UPC_W-1:0] U_EMPTY_END = 5'd21;

  // The control program. A step's jump is taken when its condition holds,
  // otherwise the next step follows.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      U_FETCH:     w = '{op: OP_FETCH,      cond: C_NO_INPUT,  target: U_FETCH};
      U_CHK_EN:    w = '{op: OP_NOP,        cond: C_DISABLED,  target: U_FETCH};
      U_CHK_CMD:   w = '{op: OP_NOP,        cond: C_REARM,     target: U_SETHUNT};
      U_DSP_HUNT:  w = '{op: OP_NOP,        cond: C_PH_HUNT,   target: U_HUNT};
      U_DSP_HEAD:  w = '{op: OP_NOP,        cond: C_PH_HEAD,   target: U_HEAD};
      U_DSP_DATA:  w = '{op: OP_NOP,        cond: C_PH_DATA,   target: U_DATA};
      U_CSUM:      w = '{op: OP_CLR_IDX,    cond: C_SUM_BAD,   target: U_BADC};
      U_CHK_ZERO:  w = '{op: OP_NOP,        cond: C_EXP_ZERO,  target: U_EMPTY};
      U_LOOP_RD:   w = '{op: OP_RD,         cond: C_NEVER,     target: U_FETCH};
      U_LOOP_EM:   w = '{op: OP_EMIT_DATA,  cond: C_EMIT_WAIT, target: U_LOOP_EM};
      U_LOOP_NX:   w = '{op: OP_INC_IDX,    cond: C_MORE,      target: U_LOOP_RD};
      U_LOOP_END:  w = '{op: OP_NOP,        cond: C_ALWAYS,    target: U_SETHUNT};
      U_HUNT:      w = '{op: OP_HUNT_CHK,   cond: C_ALWAYS,    target: U_FETCH};
      U_HEAD:      w = '{op: OP_NOP,        cond: C_BAD_HDR,   target: U_BADH};
      U_HEAD_LD:   w = '{op: OP_HEAD_LOAD,  cond: C_ALWAYS,    target: U_FETCH};
      U_BADH:      w = '{op: OP_EMIT_BADH,  cond: C_EMIT_WAIT, target: U_BADH};
      U_SETHUNT:   w = '{op: OP_SET_HUNT,   cond: C_ALWAYS,    target: U_FETCH};
      U_DATA:      w = '{op: OP_DATA_STORE, cond: C_ALWAYS,    target: U_FETCH};
      U_BADC:      w = '{op: OP_EMIT_BADC,  cond: C_EMIT_WAIT, target: U_BADC};
      U_BADC_END:  w = '{op: OP_NOP,        cond: C_ALWAYS,    target: U_SETHUNT};
      U_EMPTY:     w = '{op: OP_EMIT_EMPTY, cond: C_EMIT_WAIT, target: U_EMPTY};
      U_EMPTY_END: w = '{op: OP_NOP,        cond: C_ALWAYS,    target: U_SETHUNT};
      default:     w = '{op: OP_NOP,        cond: C_ALWAYS,    target: U_FETCH};
    endcase
    return w;
  endfunction

  // Word count as reported: saturated to the field.
  function automatic logic [WCOUNT_W-1:0] sat_count(input logic [TYPE_W-1:0] c);
    logic [WCOUNT_W-1:0] r;
    if (c > TYPE_W'({WCOUNT_W{1'b1}})) begin
      r = {WCOUNT_W{1'b1}};
    end else begin
      r = c[WCOUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/wfr_in_if.sv
// ----------------------------------------------------------------------------
// Receiver input channel
// Valid/ready channel that carries one link word or a rearm command.
// ----------------------------------------------------------------------------
interface wfr_in_if import wfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] rx_word;

  modport source (output valid, output cmd, output rx_word, input ready);
  modport sink   (input valid, input cmd, input rx_word, output ready);
endinterface

// File: sv/wfr_out_if.sv
// ----------------------------------------------------------------------------
// Receiver result channel
// Valid/ready channel that carries one frame result item.
// ----------------------------------------------------------------------------
interface wfr_out_if import wfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [TYPE_W-1:0]   frame_type;
  logic [WCOUNT_W-1:0] word_count;
  logic [DIDX_W-1:0]   data_index;
  logic [WORD_W-1:0]   data_word;
  logic                last;

  modport source (output valid, output kind, output frame_type, output word_count,
                  output data_index, output data_word, output last, input ready);
  modport sink   (input valid, input kind, input frame_type, input word_count,
                  input data_index, input data_word, input last, output ready);
endinterface

// File: sv/word_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Word frame receiver
// Hunts for the sync word, checks header and checksum, and emits the
// buffered data words of good frames or one status item per frame.
// ----------------------------------------------------------------------------
// A word that gives no result holds the input until its steps are done; each
// further data word of a frame follows a buffer read, an output load and an
// index step. The sequencer takes one step per cycle, but an emit step waits
// while the output is full.
// Reset is asynchronous: hunting, disabled, sync word 0xA55A; the word
// buffer is not cleared.
`include "assert_macros.svh"

module word_frame_receiver_top import wfr_pkg::*; #(
  parameter int unsigned MaxDataWords = MAX_WORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  wfr_in_if.sink               in_i,
  wfr_out_if.source            out_o
);

  localparam int unsigned CntW = $clog2(MaxDataWords + 1);
  localparam int unsigned IdxW = (MaxDataWords > 1) ? $clog2(MaxDataWords) : 1;
  localparam logic [CntW-1:0]   MaxCnt  = CntW'(MaxDataWords);
  localparam logic [TYPE_W-1:0] MaxCnt8 = TYPE_W'(MaxDataWords);

  ucode_t     ctrl;
  wfr_flags_t flags;

  logic              enable_q, enable_d;
  logic [WORD_W-1:0] sync_q, sync_d;
  logic              cmd_q, cmd_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [1:0]        phase_q, phase_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic [CntW-1:0]   exp_q, exp_d;
  logic [CntW-1:0]   rcv_q, rcv_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [WORD_W-1:0] sum_q, sum_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              ram_we;
  logic [WORD_W-1:0] ram_rdata;
  logic [CntW-1:0]   rcv_inc;
  logic [CntW-1:0]   idx_inc;

  wfr_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign ram_we = (ctrl.op == OP_DATA_STORE) && (rcv_q < MaxCnt);

  wfr_ram #(
    .Width (WORD_W),
    .Depth (MaxDataWords)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rcv_q[IdxW-1:0]),
    .wdata_i (word_q),
    .re_i    (ctrl.op == OP_RD),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (ctrl.op == OP_FETCH);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign rcv_inc    = rcv_q + CntW'(1);
  assign idx_inc    = idx_q + CntW'(1);

  always_comb begin
    flags.no_input  = !in_i.valid;
    flags.disabled  = !enable_q;
    flags.rearm     = cmd_q;
    flags.ph_hunt   = (phase_q == PH_HUNT);
    flags.ph_head   = (phase_q == PH_HEAD);
    flags.ph_data   = (phase_q == PH_DATA);
    flags.sum_bad   = ((sum_q + word_q) != '0);
    flags.exp_zero  = (exp_q == '0);
    flags.more      = (idx_inc < exp_q);
    flags.emit_wait = !out_free;
    flags.bad_hdr   = (word_q[TYPE_W-1:0] > MaxCnt8) || (word_q[WORD_W-1:TYPE_W] == '0);
  end

  // Configuration writes.
  always_comb begin
    enable_d = enable_q;
    sync_d   = sync_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE: enable_d = cfg_data_i[0];
        REG_SYNC:   sync_d   = cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Datapath driven by the current control word.
  always_comb begin
    cmd_d    = cmd_q;
    word_d   = word_q;
    phase_d  = phase_q;
    type_d   = type_q;
    exp_d    = exp_q;
    rcv_d    = rcv_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    out_d    = out_q;
    out_load = 1'b0;

    case (ctrl.op)
      OP_FETCH: begin
        if (accept) begin
          cmd_d  = in_i.cmd;
          word_d = in_i.rx_word;
        end
      end
      OP_HUNT_CHK: begin
        if (word_q == sync_q) begin
          phase_d = PH_HEAD;
        end
      end
      OP_HEAD_LOAD: begin
        type_d  = word_q[WORD_W-1:TYPE_W];
        exp_d   = CntW'(word_q[TYPE_W-1:0]);
        rcv_d   = '0;
        sum_d   = word_q;
        phase_d = (word_q[TYPE_W-1:0] == '0) ? PH_CSUM : PH_DATA;
      end
      OP_DATA_STORE: begin
        rcv_d   = rcv_inc;
        sum_d   = sum_q + word_q;
        phase_d = (rcv_inc >= exp_q) ? PH_CSUM : PH_DATA;
      end
      OP_CLR_IDX: begin
        idx_d = '0;
      end
      OP_INC_IDX: begin
        idx_d = idx_inc;
      end
      OP_EMIT_DATA: begin
        out_load = out_free;
        out_d    = '{kind: KIND_DATA, frame_type: type_q,
                     word_count: sat_count(TYPE_W'(exp_q)),
                     data_index: DIDX_W'(idx_q), data_word: ram_rdata,
                     last: (idx_inc == exp_q)};
      end
      OP_EMIT_BADH: begin
        out_load = out_free;
        out_d    = '{kind: KIND_BADH, frame_type: word_q[WORD_W-1:TYPE_W],
                     word_count: sat_count(word_q[TYPE_W-1:0]),
                     data_index: '0, data_word: '0, last: 1'b1};
      end
      OP_EMIT_BADC: begin
        out_load = out_free;
        out_d    = '{kind: KIND_BADC, frame_type: type_q,
                     word_count: sat_count(TYPE_W'(exp_q)),
                     data_index: '0, data_word: '0, last: 1'b1};
      end
      OP_EMIT_EMPTY: begin
        out_load = out_free;
        out_d    = '{kind: KIND_EMPTY, frame_type: type_q, word_count: '0,
                     data_index: '0, data_word: '0, last: 1'b1};
      end
      OP_SET_HUNT: begin
        phase_d = PH_HUNT;
      end
      default: ;
    endcase

    // An item leaves when taken; a new one may be loaded in the same cycle.
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      sync_q      <= SYNC_RESET;
      phase_q     <= PH_HUNT;
      type_q      <= '0;
      exp_q       <= '0;
      rcv_q       <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      enable_q    <= enable_d;
      sync_q      <= sync_d;
      phase_q     <= phase_d;
      type_q      <= type_d;
      exp_q       <= exp_d;
      rcv_q       <= rcv_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    word_q <= word_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.frame_type = out_q.frame_type;
  assign out_o.word_count = out_q.word_count;
  assign out_o.data_index = out_q.data_index;
  assign out_o.data_word  = out_q.data_word;
  assign out_o.last       = out_q.last;

  `ASSERT_STD(a_load_into_free_slot, out_load |-> (!out_valid_q || out_o.ready), "result overwritten before it was taken")
  `ASSERT_STD(a_data_phase_counts, (phase_q == PH_DATA) |-> ((exp_q != '0) && (rcv_q < exp_q)), "data phase with no word left to receive")
  `ASSERT_STD(a_count_bound, exp_q <= MaxCnt, "held word count above buffer depth")
  `ASSERT_STD(a_one_word_at_a_time, accept |=> !in_i.ready, "new word taken before the last one was processed")

endmodule

// File: sv/wfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wfr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/wfr_seq.sv
// ----------------------------------------------------------------------------
// Receiver sequencer
// Step counter over the microcode ROM with conditional jumps.
// ----------------------------------------------------------------------------
module wfr_seq import wfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wfr_flags_t flags_i,
  output ucode_t     ctrl_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           ctrl;
  logic             take;

  assign ctrl = ucode_rom(upc_q);

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:    take = 1'b1;
      C_NEVER:     take = 1'b0;
      C_NO_INPUT:  take = flags_i.no_input;
      C_DISABLED:  take = flags_i.disabled;
      C_REARM:     take = flags_i.rearm;
      C_PH_HUNT:   take = flags_i.ph_hunt;
      C_PH_HEAD:   take = flags_i.ph_head;
      C_PH_DATA:   take = flags_i.ph_data;
      C_SUM_BAD:   take = flags_i.sum_bad;
      C_EXP_ZERO:  take = flags_i.exp_zero;
      C_MORE:      take = flags_i.more;
      C_EMIT_WAIT: take = flags_i.emit_wait;
      C_BAD_HDR:   take = flags_i.bad_hdr;
      default:     take = 1'b1;
    endcase
    upc_d = take ? ctrl.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule
